// File: rtl/core/scfa_pkg.sv
package scfa_pkg;

    localparam int POS_FRAC_BITS_DFLT = 14;

    // field and register widths
    localparam int POS_W     = 16;
    localparam int RAD_W     = 15;
    localparam int STIFF_W   = 16;
    localparam int SCALE_W   = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int FORCE_W   = 32;
    localparam int SUM_W     = 40;

    // internal widths
    localparam int MAG_W    = 16;                       // |cursor - node| per axis
    localparam int LEN_W    = 17;                       // floor(sqrt(sum of squares))
    localparam int SQ_W     = 2 * LEN_W;                // sum of squares
    localparam int PEN_W    = 16;                       // penetration depth
    localparam int PS_W     = PEN_W + STIFF_W;          // pen * stiffness
    localparam int PROD_W   = PS_W + MAG_W;             // pen * stiffness * |d|
    localparam int LANE_A_W = SUM_W;                    // lane multiplier operand A
    localparam int LANE_P_W = LANE_A_W + SCALE_W;       // lane multiplier product
    localparam int QUO_W    = FORCE_W - 1;              // unsigned force magnitude
    localparam int SCALE_FRAC = 8;

    localparam int FORCE_FRAC = 16;
    localparam int STIFF_FRAC = 4;

    localparam logic [RAD_W-1:0]   CURSOR_RADIUS_RST = 15'd1638;
    localparam logic [RAD_W-1:0]   NODE_RADIUS_RST   = 15'd819;
    localparam logic [STIFF_W-1:0] STIFFNESS_RST     = 16'd640;
    localparam logic [SCALE_W-1:0] FORCE_SCALE_RST   = 16'd256;

    localparam logic [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

    typedef logic [MAG_W-1:0] t_mag;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CURSOR_RADIUS = 2'd0,
        CFG_NODE_RADIUS   = 2'd1,
        CFG_STIFFNESS     = 2'd2,
        CFG_FORCE_SCALE   = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM_GO,
        ST_NORM,
        ST_CHECK,
        ST_PMUL,
        ST_LMUL,
        ST_DIV,
        ST_ACC,
        ST_SCALE_GO,
        ST_SCALE,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        NRM_IDLE,
        NRM_SQUARE,
        NRM_ROOT
    } t_norm_state;

endpackage

// File: rtl/core/scfa_serial_mul.sv
module scfa_serial_mul #(
    parameter int A_W = 40,
    parameter int B_W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_done,
    output logic [A_W+B_W-1:0] o_p
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]   r_a;
    logic [B_W-1:0]   r_b;
    logic [P_W-1:0]   r_acc;
    logic [P_W-1:0]   n_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    // shift-add, multiplier bits taken MSB first
    always_comb begin
        n_acc = {r_acc[P_W-2:0], 1'b0} + (r_b[B_W-1] ? {{B_W{1'b0}}, r_a} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_cnt <= CNT_W'(B_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_cnt != '0) begin
            r_acc <= n_acc;
            r_b   <= {r_b[B_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

// File: rtl/core/scfa_norm.sv
module scfa_norm (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  scfa_pkg::t_mag [2:0]         i_mag,
    output logic                         o_done,
    output logic [scfa_pkg::LEN_W-1:0]   o_len
);

    import scfa_pkg::*;

    localparam int REM_W = LEN_W + 2;
    localparam int CNT_W = $clog2(LEN_W + 1);

    t_norm_state        r_state;
    t_norm_state        n_state;
    t_mag [2:0]         r_m;
    t_mag [2:0]         r_b;
    logic [SQ_W-1:0]    r_sq;
    logic [SQ_W-1:0]    n_sq;
    logic [REM_W-1:0]   r_rem;
    logic [LEN_W-1:0]   r_root;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic               sq_step;
    logic               rt_step;
    logic               last_step;
    logic [REM_W+1:0]   t_rem;
    logic [REM_W+1:0]   t_trial;
    logic [REM_W+1:0]   t_diff;
    logic               t_ge;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            NRM_IDLE:   if (i_go) n_state = NRM_SQUARE;
            NRM_SQUARE: if (last_step) n_state = NRM_ROOT;
            NRM_ROOT:   if (last_step) n_state = NRM_IDLE;
            default:    n_state = NRM_IDLE;
        endcase
    end

    always_comb begin
        sq_step   = (r_state == NRM_SQUARE);
        rt_step   = (r_state == NRM_ROOT);
        last_step = (r_cnt == CNT_W'(1));
    end

    // three squares summed at once, one multiplier bit per axis each cycle
    always_comb begin
        n_sq = {r_sq[SQ_W-2:0], 1'b0}
             + (r_b[0][MAG_W-1] ? SQ_W'(r_m[0]) : '0)
             + (r_b[1][MAG_W-1] ? SQ_W'(r_m[1]) : '0)
             + (r_b[2][MAG_W-1] ? SQ_W'(r_m[2]) : '0);
    end

    // one root digit: bring down two bits, try (root << 2) | 1
    always_comb begin
        t_rem   = {r_rem, r_sq[SQ_W-1:SQ_W-2]};
        t_trial = (REM_W+2)'({r_root, 2'b01});
        t_ge    = (t_rem >= t_trial);
        t_diff  = t_rem - t_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= NRM_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            if (r_state == NRM_IDLE && i_go) begin
                r_cnt <= CNT_W'(MAG_W);
            end else if (sq_step) begin
                r_cnt <= last_step ? CNT_W'(LEN_W) : r_cnt - 1'b1;
            end else if (rt_step) begin
                r_cnt <= r_cnt - 1'b1;
                if (last_step) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == NRM_IDLE && i_go) begin
            r_m  <= i_mag;
            r_b  <= i_mag;
            r_sq <= '0;
        end else if (sq_step) begin
            r_sq <= n_sq;
            for (int i = 0; i < 3; i++) begin
                r_b[i] <= {r_b[i][MAG_W-2:0], 1'b0};
            end
            if (last_step) begin
                r_rem  <= '0;
                r_root <= '0;
            end
        end else if (rt_step) begin
            r_sq <= {r_sq[SQ_W-3:0], 2'b00};
            if (t_ge) begin
                r_rem  <= t_diff[REM_W-1:0];
                r_root <= {r_root[LEN_W-2:0], 1'b1};
            end else begin
                r_rem  <= t_rem[REM_W-1:0];
                r_root <= {r_root[LEN_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_len  = r_root;

endmodule

// File: rtl/core/scfa_divider.sv
module scfa_divider #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 18
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic [NUM_W-1:0]             i_num,
    input  logic [DEN_W-1:0]             i_den,
    output logic                         o_done,
    output logic                         o_sat,
    output logic [scfa_pkg::QUO_W-1:0]   o_quo
);

    import scfa_pkg::*;

    // rounded quotient (2*num + den) / (2*den), restoring, one bit a cycle
    localparam int N_W   = NUM_W + 2;
    localparam int D_W   = DEN_W + 1;
    localparam int HI_W  = N_W - QUO_W;
    localparam int C_W   = (HI_W > D_W) ? HI_W : D_W;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [N_W-1:0]   n_full;
    logic [D_W-1:0]   d_full;
    logic [C_W-1:0]   hi_c;
    logic [C_W-1:0]   d_c;
    logic             sat;
    logic [D_W-1:0]   r_d;
    logic [D_W-1:0]   r_rem;
    logic [QUO_W-1:0] r_low;
    logic [QUO_W-1:0] r_q;
    logic             r_sat;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [D_W:0]     t_rem;
    logic [D_W:0]     t_diff;
    logic             t_ge;

    always_comb begin
        n_full = {1'b0, i_num, 1'b0} + N_W'(i_den);
        d_full = {i_den, 1'b0};
        hi_c   = C_W'(n_full[N_W-1:QUO_W]);
        d_c    = C_W'(d_full);
        // quotient would need more than QUO_W bits
        sat    = (hi_c >= d_c);
    end

    always_comb begin
        t_rem  = {r_rem, r_low[QUO_W-1]};
        t_ge   = (t_rem >= {1'b0, r_d});
        t_diff = t_rem - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_cnt <= CNT_W'(QUO_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_d   <= d_full;
            r_rem <= hi_c[D_W-1:0];
            r_low <= n_full[QUO_W-1:0];
            r_sat <= sat;
            r_q   <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= t_ge ? t_diff[D_W-1:0] : t_rem[D_W-1:0];
            r_q   <= {r_q[QUO_W-2:0], t_ge};
            r_low <= {r_low[QUO_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_sat  = r_sat;
    assign o_quo  = r_q;

endmodule

// File: rtl/core/sphere_contact_force_accumulator.sv
// Penalty contact between a cursor sphere and a list of node spheres. Each
// input transfer carries the cursor and one node position; the block returns
// the negated contact force on that node (Q16.16) and adds the force to a
// running sum per axis. The transfer with tlast set also returns the summed
// force times force_scale, and clears the sum. One item is worked at a time,
// through bit-serial units: the distance by squaring and then square root,
// the force by pen*stiffness, the per-axis multiply and restoring division,
// and the frame total by scaling. An item with no contact skips the force
// units. A new item is taken while the previous result still waits in the
// output register. Configuration must be written only while idle; the
// block itself does not enforce this.
module sphere_contact_force_accumulator #(
    parameter int POS_FRAC_BITS = scfa_pkg::POS_FRAC_BITS_DFLT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // cfg
    input  logic                               i_cfg_we,
    input  logic [scfa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [scfa_pkg::CFG_W-1:0]         i_cfg_wdata,
    // node stream in
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // cursor_x, cursor_y, cursor_z, node_x, node_y, node_z
    input  logic [95:0]                        i_s_axis_tdata,
    input  logic                               i_s_axis_tlast,
    // force stream out
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // node_force_x, node_force_y, node_force_z,
    // total_force_x, total_force_y, total_force_z
    output logic [191:0]                       o_m_axis_tdata,
    // total_valid
    output logic                               o_m_axis_tuser
);

    import scfa_pkg::*;

    localparam int UP_RAW = FORCE_FRAC - STIFF_FRAC - POS_FRAC_BITS;
    localparam int UP_SH  = (UP_RAW > 0) ? UP_RAW : 0;
    localparam int DN_SH  = (UP_RAW < 0) ? -UP_RAW : 0;
    localparam int NUM_W  = PROD_W + UP_SH;
    localparam int DEN_W  = PEN_W + DN_SH;
    localparam int RND_W  = LANE_P_W + 1;
    localparam int TQ_W   = RND_W - SCALE_FRAC;

    t_state r_state;
    t_state n_state;

    // configuration
    logic [RAD_W-1:0]   r_cursor_radius;
    logic [RAD_W-1:0]   r_node_radius;
    logic [STIFF_W-1:0] r_stiffness;
    logic [SCALE_W-1:0] r_force_scale;

    // item
    t_mag [2:0]        r_mag;
    logic [2:0]        r_neg;
    logic              r_last;
    logic              r_hit;
    t_mag [2:0]        in_mag;
    logic [2:0]        in_neg;
    logic [POS_W:0]    in_d [3];

    // control
    logic accept;
    logic out_free;
    logic s_ready;
    logic norm_go;
    logic pmul_go;
    logic lane_go;
    logic lane_scale;
    logic div_go;
    logic acc_en;
    logic out_load;

    // units
    logic                 norm_done;
    logic [LEN_W-1:0]     len;
    logic [PEN_W-1:0]     rad_sum;
    logic [PEN_W-1:0]     pen;
    logic                 contact;
    logic                 pmul_done;
    logic [PS_W-1:0]      pmul_p;
    logic [2:0]           lane_done;
    logic [LANE_A_W-1:0]  lane_a [3];
    logic [SCALE_W-1:0]   lane_b [3];
    logic [LANE_P_W-1:0]  lane_p [3];
    logic [2:0]           div_done;
    logic [2:0]           div_sat;
    logic [QUO_W-1:0]     div_q [3];
    logic [NUM_W-1:0]     div_num [3];
    logic [DEN_W-1:0]     div_den;

    // accumulation and output
    logic [SUM_W-1:0]     r_sum [3];
    logic [SUM_W-1:0]     sum_next [3];
    logic [SUM_W-1:0]     sum_mag [3];
    logic [SUM_W:0]       sum_ext [3];
    logic [FORCE_W-1:0]   f_mag [3];
    logic [FORCE_W-1:0]   f_val [3];
    logic [FORCE_W-1:0]   r_node_f [3];
    logic [RND_W-1:0]     tot_rnd [3];
    logic [TQ_W-1:0]      tot_q [3];
    logic [FORCE_W-1:0]   tot_f [3];
    logic                 r_m_valid;
    logic [191:0]         r_m_data;
    logic                 r_m_user;

    assign accept   = i_s_axis_tvalid && s_ready;
    assign out_free = !r_m_valid || i_m_axis_tready;

    // ---------------------------------------------------------------- fsm
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (accept) n_state = ST_NORM_GO;
            ST_NORM_GO:  n_state = ST_NORM;
            ST_NORM:     if (norm_done) n_state = ST_CHECK;
            ST_CHECK:    n_state = contact ? ST_PMUL : ST_ACC;
            ST_PMUL:     if (pmul_done) n_state = ST_LMUL;
            ST_LMUL:     if (&lane_done) n_state = ST_DIV;
            ST_DIV:      if (&div_done) n_state = ST_ACC;
            ST_ACC:      n_state = r_last ? ST_SCALE_GO : ST_OUT;
            ST_SCALE_GO: n_state = ST_SCALE;
            ST_SCALE:    if (&lane_done) n_state = ST_OUT;
            ST_OUT:      if (out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = (r_state == ST_IDLE);
        norm_go    = (r_state == ST_NORM_GO);
        pmul_go    = (r_state == ST_CHECK) && contact;
        lane_go    = ((r_state == ST_PMUL) && pmul_done) || (r_state == ST_SCALE_GO);
        lane_scale = (r_state == ST_SCALE_GO);
        div_go     = (r_state == ST_LMUL) && (&lane_done);
        acc_en     = (r_state == ST_ACC);
        out_load   = (r_state == ST_OUT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------- cfg
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_radius <= CURSOR_RADIUS_RST;
            r_node_radius   <= NODE_RADIUS_RST;
            r_stiffness     <= STIFFNESS_RST;
            r_force_scale   <= FORCE_SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CURSOR_RADIUS: r_cursor_radius <= i_cfg_wdata[RAD_W-1:0];
                CFG_NODE_RADIUS:   r_node_radius   <= i_cfg_wdata[RAD_W-1:0];
                CFG_STIFFNESS:     r_stiffness     <= i_cfg_wdata[STIFF_W-1:0];
                CFG_FORCE_SCALE:   r_force_scale   <= i_cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- input
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_d[i]   = {i_s_axis_tdata[POS_W*i + POS_W-1], i_s_axis_tdata[POS_W*i +: POS_W]}
                      - {i_s_axis_tdata[POS_W*(i+3) + POS_W-1],
                         i_s_axis_tdata[POS_W*(i+3) +: POS_W]};
            in_neg[i] = in_d[i][POS_W];
            in_mag[i] = in_neg[i] ? MAG_W'(~in_d[i] + 1'b1) : in_d[i][MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mag  <= in_mag;
            r_neg  <= in_neg;
            r_last <= i_s_axis_tlast;
        end
        if (r_state == ST_CHECK) begin
            r_hit <= contact;
        end
    end

    // ---------------------------------------------------------------- units
    scfa_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (norm_go),
        .i_mag   (r_mag),
        .o_done  (norm_done),
        .o_len   (len)
    );

    assign rad_sum = {1'b0, r_cursor_radius} + {1'b0, r_node_radius};
    assign contact = (len != '0) && (len <= LEN_W'(rad_sum));
    assign pen     = rad_sum - len[PEN_W-1:0];

    scfa_serial_mul #(
        .A_W (PEN_W),
        .B_W (STIFF_W)
    ) u_pmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (pmul_go),
        .i_a     (pen),
        .i_b     (r_stiffness),
        .o_done  (pmul_done),
        .o_p     (pmul_p)
    );

    assign div_den = DEN_W'(len[PEN_W-1:0]) << DN_SH;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        // reused: pen*stiffness*|d| per axis, then sum*force_scale at frame end
        assign sum_mag[g] = r_sum[g][SUM_W-1] ? (~r_sum[g] + 1'b1) : r_sum[g];
        assign lane_a[g]  = lane_scale ? sum_mag[g] : LANE_A_W'(pmul_p);
        assign lane_b[g]  = lane_scale ? r_force_scale : r_mag[g];

        scfa_serial_mul #(
            .A_W (LANE_A_W),
            .B_W (SCALE_W)
        ) u_lmul (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_go    (lane_go),
            .i_a     (lane_a[g]),
            .i_b     (lane_b[g]),
            .o_done  (lane_done[g]),
            .o_p     (lane_p[g])
        );

        assign div_num[g] = NUM_W'(lane_p[g][PROD_W-1:0]) << UP_SH;

        scfa_divider #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_go    (div_go),
            .i_num   (div_num[g]),
            .i_den   (div_den),
            .o_done  (div_done[g]),
            .o_sat   (div_sat[g]),
            .o_quo   (div_q[g])
        );
    end

    // ---------------------------------------------------------------- accumulate
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!r_hit) begin
                f_mag[i] = '0;
            end else if (div_sat[i]) begin
                f_mag[i] = FORCE_MAX;
            end else begin
                f_mag[i] = {1'b0, div_q[i]};
            end
            f_val[i]   = r_neg[i] ? (~f_mag[i] + 1'b1) : f_mag[i];
            sum_ext[i] = {r_sum[i][SUM_W-1], r_sum[i]}
                       + {{(SUM_W-FORCE_W+1){f_val[i][FORCE_W-1]}}, f_val[i]};
            // clamp at the 40-bit bounds
            if (sum_ext[i][SUM_W] != sum_ext[i][SUM_W-1]) begin
                sum_next[i] = sum_ext[i][SUM_W] ? SUM_MIN : SUM_MAX;
            end else begin
                sum_next[i] = sum_ext[i][SUM_W-1:0];
            end
        end
    end

    // scaled total: round half away from zero on the magnitude, then clamp
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            tot_rnd[i] = {1'b0, lane_p[i]} + RND_W'(1 << (SCALE_FRAC - 1));
            tot_q[i]   = tot_rnd[i][RND_W-1:SCALE_FRAC];
            if (r_sum[i][SUM_W-1]) begin
                if (tot_q[i] > TQ_W'(FORCE_MIN)) begin
                    tot_f[i] = FORCE_MIN;
                end else begin
                    tot_f[i] = ~tot_q[i][FORCE_W-1:0] + 1'b1;
                end
            end else begin
                if (tot_q[i] > TQ_W'(FORCE_MAX)) begin
                    tot_f[i] = FORCE_MAX;
                end else begin
                    tot_f[i] = tot_q[i][FORCE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= '0;
            end
        end else if (acc_en) begin
            r_sum <= sum_next;
        end else if (out_load && r_last) begin
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_en) begin
            for (int i = 0; i < 3; i++) begin
                r_node_f[i] <= ~f_val[i] + 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= {r_last ? tot_f[2] : '0,
                         r_last ? tot_f[1] : '0,
                         r_last ? tot_f[0] : '0,
                         r_node_f[2], r_node_f[1], r_node_f[0]};
            r_m_user <= r_last;
        end
    end

    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

endmodule
